// File: design/lru_keyed_cache_table_assert.svh
// ----------------------------------------------------------------------------
// LRU keyed cache table assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef LRU_KEYED_CACHE_TABLE_ASSERT_SVH
`define LRU_KEYED_CACHE_TABLE_ASSERT_SVH

// Same-cycle implication, checked while reset is released.
`define LKCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released.
`define LKCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lkct_pkg.sv
// ----------------------------------------------------------------------------
// LRU keyed cache table package
// Sizes, beat layouts, command and status codes, and shared types.
// ----------------------------------------------------------------------------
package lkct_pkg;

    localparam int ENTRIES  = 64;
    localparam int IDX_W    = $clog2(ENTRIES);

    localparam int CMD_W    = 3;
    localparam int KEY_W    = 64;
    localparam int STORE_W  = 3;
    localparam int HASH_W   = 256;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 64;

    // Input beat layout.
    localparam int S_KEY_LSB    = 0;
    localparam int S_STORE_LSB  = S_KEY_LSB + KEY_W;
    localparam int S_HASH_LSB   = S_STORE_LSB + STORE_W;
    localparam int S_NOW_LSB    = S_HASH_LSB + HASH_W;
    localparam int S_FIELDS_W   = S_NOW_LSB + STAMP_W;
    localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;

    localparam int S_CMD_LSB     = 0;
    localparam int S_HGIVEN_BIT  = S_CMD_LSB + CMD_W;
    localparam int S_PAYLOAD_BIT = S_HGIVEN_BIT + 1;
    localparam int S_TUSER_W     = S_PAYLOAD_BIT + 1;

    // Output beat layout.
    localparam int M_HIT_LSB   = 0;
    localparam int M_MISS_LSB  = M_HIT_LSB + COUNT_W;
    localparam int M_EVICT_LSB = M_MISS_LSB + COUNT_W;
    localparam int M_TDATA_W   = M_EVICT_LSB + COUNT_W;
    localparam int M_TUSER_W   = STATUS_W;

    localparam logic [CMD_W-1:0] CMD_GET   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INVAL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STATS = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NODATA = 2'd3;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [STORE_W-1:0] store;
        logic [KEY_W-1:0]   key;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_HASH_CMP,
        ST_DONE
    } state_t;

endpackage

// File: design/lru_keyed_cache_table.sv
// ----------------------------------------------------------------------------
// LRU keyed cache table
// A fully associative directory of keyed entries with least-recently-used
// replacement. Get, set and invalidate requests sweep the entry memory
// through its single read port, one slot per cycle, before the result is
// decided; a get that carries a hash then reads the hash memory and
// compares it with the given hash. Clear, statistics, unused codes and
// a set without data skip the sweep. One request is worked on at a time;
// the next one is taken while the previous result waits in the output
// register. Every request gives exactly one result beat with a status and
// the three running counters.
// ----------------------------------------------------------------------------
module lru_keyed_cache_table
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // module_key, datastore, hash_word0..3, now_time, zero fill
    input  logic [lkct_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // command, hash_given, payload_present
    input  logic [lkct_pkg::S_TUSER_W-1:0]  s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // hit_total, miss_total, evict_total
    output logic [lkct_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // status
    output logic [lkct_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    lkct_pkg::state_t state_reg, state_next;

    // Captured request.
    logic [lkct_pkg::CMD_W-1:0]   cmd_reg;
    logic [lkct_pkg::KEY_W-1:0]   key_reg;
    logic [lkct_pkg::STORE_W-1:0] store_reg;
    logic                         hash_given_reg;
    logic [lkct_pkg::HASH_W-1:0]  hash_reg;
    logic                         payload_reg;
    logic [lkct_pkg::STAMP_W-1:0] now_reg;

    // Sweep control and trackers.
    logic [lkct_pkg::IDX_W-1:0]   scan_cnt_reg;
    logic                         cmp_valid_reg;
    logic [lkct_pkg::IDX_W-1:0]   cmp_idx_reg;
    logic                         match_found_reg;
    logic [lkct_pkg::IDX_W-1:0]   match_idx_reg;
    logic                         free_found_reg;
    logic [lkct_pkg::IDX_W-1:0]   free_idx_reg;
    logic                         victim_found_reg;
    logic [lkct_pkg::IDX_W-1:0]   victim_idx_reg;
    logic [lkct_pkg::STAMP_W-1:0] oldest_reg;

    // Slot state: free when neither bit is set.
    logic [lkct_pkg::ENTRIES-1:0] ready_reg;
    logic [lkct_pkg::ENTRIES-1:0] inval_reg;

    logic [lkct_pkg::COUNT_W-1:0] hit_reg;
    logic [lkct_pkg::COUNT_W-1:0] miss_reg;
    logic [lkct_pkg::COUNT_W-1:0] evict_reg;
    logic [lkct_pkg::STATUS_W-1:0] status_reg;

    logic                          out_valid_reg;
    logic [lkct_pkg::STATUS_W-1:0] out_status_reg;
    logic [lkct_pkg::COUNT_W-1:0]  out_hit_reg;
    logic [lkct_pkg::COUNT_W-1:0]  out_miss_reg;
    logic [lkct_pkg::COUNT_W-1:0]  out_evict_reg;

    // Memories.
    lkct_pkg::entry_t             ent_mem [lkct_pkg::ENTRIES];
    lkct_pkg::entry_t             ent_rdata_reg;
    logic [lkct_pkg::HASH_W-1:0]  hash_mem [lkct_pkg::ENTRIES];
    logic [lkct_pkg::HASH_W-1:0]  hash_rdata_reg;

    // Datapath controls.
    logic                          in_beat;
    logic                          out_load;
    logic [lkct_pkg::CMD_W-1:0]    in_cmd;
    logic                          in_payload;
    logic                          ent_we;
    logic [lkct_pkg::IDX_W-1:0]    wr_idx;
    lkct_pkg::entry_t              ent_wdata;
    logic                          hash_we;
    logic                          set_ready;
    logic                          set_inval;
    logic                          clear_all;
    logic                          hit_inc;
    logic                          miss_inc;
    logic                          evict_inc;
    logic [lkct_pkg::STATUS_W-1:0] status_next;
    logic                          cmp_ready;
    logic                          cmp_free;

    assign s_axis_tready = (state_reg == lkct_pkg::ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = s_axis_tuser[lkct_pkg::S_CMD_LSB +: lkct_pkg::CMD_W];
    assign in_payload    = s_axis_tuser[lkct_pkg::S_PAYLOAD_BIT];
    assign out_load      = (state_reg == lkct_pkg::ST_DONE) && (!out_valid_reg || m_axis_tready);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {out_evict_reg, out_miss_reg, out_hit_reg};

    assign ent_wdata.key   = key_reg;
    assign ent_wdata.store = store_reg;
    assign ent_wdata.stamp = now_reg;

    assign cmp_ready = ready_reg[cmp_idx_reg];
    assign cmp_free  = !ready_reg[cmp_idx_reg] && !inval_reg[cmp_idx_reg];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lkct_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    if ((in_cmd == lkct_pkg::CMD_GET) || (in_cmd == lkct_pkg::CMD_INVAL) ||
                        ((in_cmd == lkct_pkg::CMD_SET) && in_payload))
                    begin
                        state_next = lkct_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = lkct_pkg::ST_DECIDE;
                    end
                end
            end
            lkct_pkg::ST_SCAN:
            begin
                if (scan_cnt_reg == lkct_pkg::IDX_W'(lkct_pkg::ENTRIES - 1))
                begin
                    state_next = lkct_pkg::ST_SCAN_END;
                end
            end
            lkct_pkg::ST_SCAN_END:
            begin
                state_next = lkct_pkg::ST_DECIDE;
            end
            lkct_pkg::ST_DECIDE:
            begin
                if ((cmd_reg == lkct_pkg::CMD_GET) && match_found_reg && hash_given_reg)
                begin
                    state_next = lkct_pkg::ST_HASH_CMP;
                end
                else
                begin
                    state_next = lkct_pkg::ST_DONE;
                end
            end
            lkct_pkg::ST_HASH_CMP:
            begin
                state_next = lkct_pkg::ST_DONE;
            end
            lkct_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = lkct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lkct_pkg::ST_IDLE;
            end
        endcase
    end

    // Actions taken once the sweep has settled.
    always_comb
    begin
        ent_we      = 1'b0;
        hash_we     = 1'b0;
        wr_idx      = match_idx_reg;
        set_ready   = 1'b0;
        set_inval   = 1'b0;
        clear_all   = 1'b0;
        hit_inc     = 1'b0;
        miss_inc    = 1'b0;
        evict_inc   = 1'b0;
        status_next = lkct_pkg::STATUS_OK;
        unique case (state_reg)
            lkct_pkg::ST_DECIDE:
            begin
                case (cmd_reg)
                    lkct_pkg::CMD_GET:
                    begin
                        if (!match_found_reg)
                        begin
                            miss_inc    = 1'b1;
                            status_next = lkct_pkg::STATUS_MISS;
                        end
                        else if (!hash_given_reg)
                        begin
                            ent_we  = 1'b1;
                            hit_inc = 1'b1;
                        end
                    end
                    lkct_pkg::CMD_SET:
                    begin
                        if (!payload_reg)
                        begin
                            status_next = lkct_pkg::STATUS_NODATA;
                        end
                        else if (match_found_reg || free_found_reg || victim_found_reg)
                        begin
                            ent_we    = 1'b1;
                            hash_we   = hash_given_reg;
                            set_ready = 1'b1;
                            if (match_found_reg)
                            begin
                                wr_idx = match_idx_reg;
                            end
                            else if (free_found_reg)
                            begin
                                wr_idx = free_idx_reg;
                            end
                            else
                            begin
                                wr_idx    = victim_idx_reg;
                                evict_inc = 1'b1;
                            end
                        end
                        else
                        begin
                            status_next = lkct_pkg::STATUS_FULL;
                        end
                    end
                    lkct_pkg::CMD_INVAL:
                    begin
                        set_inval = match_found_reg;
                    end
                    lkct_pkg::CMD_CLEAR:
                    begin
                        clear_all = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            lkct_pkg::ST_HASH_CMP:
            begin
                if (hash_rdata_reg != hash_reg)
                begin
                    set_inval   = 1'b1;
                    miss_inc    = 1'b1;
                    status_next = lkct_pkg::STATUS_MISS;
                end
                else
                begin
                    ent_we  = 1'b1;
                    hit_inc = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lkct_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Request capture; payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            cmd_reg        <= in_cmd;
            payload_reg    <= in_payload;
            hash_given_reg <= s_axis_tuser[lkct_pkg::S_HGIVEN_BIT];
            key_reg        <= s_axis_tdata[lkct_pkg::S_KEY_LSB +: lkct_pkg::KEY_W];
            store_reg      <= s_axis_tdata[lkct_pkg::S_STORE_LSB +: lkct_pkg::STORE_W];
            hash_reg       <= s_axis_tdata[lkct_pkg::S_HASH_LSB +: lkct_pkg::HASH_W];
            now_reg        <= s_axis_tdata[lkct_pkg::S_NOW_LSB +: lkct_pkg::STAMP_W];
        end
    end

    // Entry memory: the sweep address is read every cycle.
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[wr_idx] <= ent_wdata;
        end
        ent_rdata_reg <= ent_mem[scan_cnt_reg];
    end

    // Hash memory: only the matched slot is ever read.
    always_ff @(posedge clk)
    begin
        if (hash_we)
        begin
            hash_mem[wr_idx] <= hash_reg;
        end
        hash_rdata_reg <= hash_mem[match_idx_reg];
    end

    // Sweep: the compare stage works on the slot addressed in the cycle before.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg     <= '0;
            cmp_valid_reg    <= 1'b0;
            cmp_idx_reg      <= '0;
            match_found_reg  <= 1'b0;
            match_idx_reg    <= '0;
            free_found_reg   <= 1'b0;
            free_idx_reg     <= '0;
            victim_found_reg <= 1'b0;
            victim_idx_reg   <= '0;
            oldest_reg       <= '0;
        end
        else
        begin
            cmp_valid_reg <= (state_reg == lkct_pkg::ST_SCAN);
            cmp_idx_reg   <= scan_cnt_reg;
            if (state_reg == lkct_pkg::ST_SCAN)
            begin
                if (scan_cnt_reg == lkct_pkg::IDX_W'(lkct_pkg::ENTRIES - 1))
                begin
                    scan_cnt_reg <= '0;
                end
                else
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
            end
            if (in_beat)
            begin
                match_found_reg  <= 1'b0;
                free_found_reg   <= 1'b0;
                victim_found_reg <= 1'b0;
            end
            else if (cmp_valid_reg)
            begin
                if (!match_found_reg && cmp_ready && (ent_rdata_reg.key == key_reg) &&
                    (ent_rdata_reg.store == store_reg))
                begin
                    match_found_reg <= 1'b1;
                    match_idx_reg   <= cmp_idx_reg;
                end
                if (!free_found_reg && cmp_free)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= cmp_idx_reg;
                end
                // Strictly older only, so the lowest index wins a tie.
                if (cmp_ready && (!victim_found_reg || (ent_rdata_reg.stamp < oldest_reg)))
                begin
                    victim_found_reg <= 1'b1;
                    victim_idx_reg   <= cmp_idx_reg;
                    oldest_reg       <= ent_rdata_reg.stamp;
                end
            end
        end
    end

    // Slot state bits and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= '0;
            inval_reg <= '0;
            hit_reg   <= '0;
            miss_reg  <= '0;
            evict_reg <= '0;
        end
        else if (clear_all)
        begin
            ready_reg <= '0;
            inval_reg <= '0;
            hit_reg   <= '0;
            miss_reg  <= '0;
            evict_reg <= '0;
        end
        else
        begin
            if (set_ready)
            begin
                ready_reg[wr_idx] <= 1'b1;
                inval_reg[wr_idx] <= 1'b0;
            end
            else if (set_inval)
            begin
                ready_reg[wr_idx] <= 1'b0;
                inval_reg[wr_idx] <= 1'b1;
            end
            if (hit_inc)
            begin
                hit_reg <= hit_reg + 1'b1;
            end
            if (miss_inc)
            begin
                miss_reg <= miss_reg + 1'b1;
            end
            if (evict_inc)
            begin
                evict_reg <= evict_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == lkct_pkg::ST_DECIDE) || (state_reg == lkct_pkg::ST_HASH_CMP))
        begin
            status_reg <= status_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_hit_reg    <= hit_reg;
            out_miss_reg   <= miss_reg;
            out_evict_reg  <= evict_reg;
        end
    end

endmodule

// File: design/lkct_checker.sv
// ----------------------------------------------------------------------------
// LRU keyed cache table checker
// Port-level checks of ordering, counters and status against the commands.
// ----------------------------------------------------------------------------
`include "lru_keyed_cache_table_assert.svh"

module lkct_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [lkct_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [lkct_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic [lkct_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    logic                          push;
    logic                          pop;
    logic [1:0]                    cnt_reg;
    logic [1:0]                    cnt_after_pop;
    logic [lkct_pkg::CMD_W-1:0]    cmd0_reg;
    logic [lkct_pkg::CMD_W-1:0]    cmd1_reg;
    logic [lkct_pkg::COUNT_W-1:0]  prev_hit_reg;
    logic [lkct_pkg::COUNT_W-1:0]  prev_miss_reg;
    logic [lkct_pkg::COUNT_W-1:0]  out_hit;
    logic [lkct_pkg::COUNT_W-1:0]  out_miss;
    logic [lkct_pkg::COUNT_W-1:0]  out_evict;
    logic [lkct_pkg::COUNT_W-1:0]  sum_now;
    logic [lkct_pkg::COUNT_W-1:0]  sum_prev;

    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign cnt_after_pop = cnt_reg - {1'b0, pop};
    assign out_hit       = m_axis_tdata[lkct_pkg::M_HIT_LSB +: lkct_pkg::COUNT_W];
    assign out_miss      = m_axis_tdata[lkct_pkg::M_MISS_LSB +: lkct_pkg::COUNT_W];
    assign out_evict     = m_axis_tdata[lkct_pkg::M_EVICT_LSB +: lkct_pkg::COUNT_W];
    assign sum_now       = out_hit + out_miss;
    assign sum_prev      = prev_hit_reg + prev_miss_reg + 1'b1;

    // Commands of requests whose result beat is still owed, oldest first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            cmd0_reg      <= lkct_pkg::CMD_STATS;
            cmd1_reg      <= lkct_pkg::CMD_STATS;
            prev_hit_reg  <= '0;
            prev_miss_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_after_pop + {1'b0, push};
            if (pop)
            begin
                prev_hit_reg  <= out_hit;
                prev_miss_reg <= out_miss;
            end
            if (push && (cnt_after_pop == 2'd0))
            begin
                cmd0_reg <= s_axis_tuser[lkct_pkg::S_CMD_LSB +: lkct_pkg::CMD_W];
            end
            else if (pop)
            begin
                cmd0_reg <= cmd1_reg;
            end
            if (push && (cnt_after_pop != 2'd0))
            begin
                cmd1_reg <= s_axis_tuser[lkct_pkg::S_CMD_LSB +: lkct_pkg::CMD_W];
            end
        end
    end

    `LKCT_ASSERT_NEXT(a_out_valid_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat withdrawn before it was taken")
    `LKCT_ASSERT_NEXT(a_one_request, push, !s_axis_tready, "second request taken while one is in work")
    `LKCT_ASSERT_NOW(a_clear_zeroes, pop && (cmd0_reg == lkct_pkg::CMD_CLEAR), (out_hit == '0) && (out_miss == '0) && (out_evict == '0), "clear left a counter nonzero")
    `LKCT_ASSERT_NOW(a_get_counts_once, pop && (cmd0_reg == lkct_pkg::CMD_GET), sum_now == sum_prev, "get did not count exactly one hit or miss")
    `LKCT_ASSERT_NOW(a_nodata_on_set, pop && (m_axis_tuser == lkct_pkg::STATUS_NODATA), cmd0_reg == lkct_pkg::CMD_SET, "no-data status on a request that is not a set")

endmodule

bind lru_keyed_cache_table lkct_checker u_lkct_checker (.*);
